/* hdl/assert_macros.svh */
// Assertion helpers shared by the slug stream modules.
// Each macro expects a clk and an active-low rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define U8S_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define U8S_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/u8s_pkg.sv */
// Package for the UTF-8 name slug stream: payload structs, decoder modes,
// queue sizing and the accent fold table. No dependencies.
`default_nettype none

package u8s_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_name;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       slug_empty;
  } out_item_t;

  // Results of one input byte: up to three characters, or an end marker when
  // n is zero and last is set.
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] ch;
    logic            last;
    logic            slug_empty;
  } bundle_t;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_AFTER_C3 = 2'd1,
    MODE_AFTER_C5 = 2'd2,
    MODE_SKIP     = 2'd3
  } decode_mode_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] MAX_LEN_RESET = 8'd128;
  localparam logic [7:0] LEAD_C3       = 8'hC3;
  localparam logic [7:0] LEAD_C5       = 8'hC5;
  localparam logic [7:0] OE_LOWER      = 8'h93;
  localparam logic [7:0] OE_UPPER      = 8'h92;
  localparam logic [7:0] CHAR_HYPHEN   = 8'h2D;
  localparam logic [7:0] CHAR_SPACE    = 8'h00;

  // Byte after C3 folded to a plain letter; zero acts as a separator.
  function automatic logic [7:0] fold_after_c3(input logic [7:0] c);
    logic [7:0] r;
    begin
      r = CHAR_SPACE;
      priority if (c >= 8'h80 && c <= 8'h85) r = "a";
      else if (c == 8'h87)                  r = "c";
      else if (c >= 8'h88 && c <= 8'h8B)    r = "e";
      else if (c >= 8'h8C && c <= 8'h8F)    r = "i";
      else if (c >= 8'h92 && c <= 8'h96)    r = "o";
      else if (c >= 8'h99 && c <= 8'h9C)    r = "u";
      else if (c == 8'h9F)                  r = "s";
      else if (c >= 8'hA0 && c <= 8'hA5)    r = "a";
      else if (c == 8'hA7)                  r = "c";
      else if (c >= 8'hA8 && c <= 8'hAB)    r = "e";
      else if (c >= 8'hAC && c <= 8'hAF)    r = "i";
      else if (c >= 8'hB2 && c <= 8'hB6)    r = "o";
      else if (c >= 8'hB9 && c <= 8'hBC)    r = "u";
      else if (c == 8'hBF)                  r = "y";
      else                                  r = CHAR_SPACE;
      return r;
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/u8s_front.sv */
// Front end: accepts input bytes, decodes UTF-8, tracks slug length and gap
// state, and pushes one result bundle per productive byte. Uses u8s_pkg.
`default_nettype none
`include "assert_macros.svh"

module u8s_front
  import u8s_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] max_len,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  input  wire logic       q_full,
  output logic            q_push,
  output bundle_t         q_data
);

  typedef struct packed {
    logic [7:0] cnt;
    logic       gap;
    logic [1:0] n;
    logic [7:0] c0;
    logic [7:0] c1;
  } take_res_t;

  // One folded character into the slug builder: optional hyphen, then char.
  function automatic take_res_t take_char(input logic [7:0] cnt, input logic gap,
                                          input logic [7:0] ch, input logic [7:0] maxlen);
    take_res_t r;
    logic      up;
    logic      lo;
    logic      dg;
    logic      sep;
    logic [7:0] c;
    begin
      r.cnt = cnt;
      r.gap = gap;
      r.n   = 2'd0;
      r.c0  = CHAR_SPACE;
      r.c1  = CHAR_SPACE;
      up  = (ch >= "A") && (ch <= "Z");
      lo  = (ch >= "a") && (ch <= "z");
      dg  = (ch >= "0") && (ch <= "9");
      c   = up ? ch + 8'h20 : ch;
      sep = gap && (cnt != 8'd0) && (cnt < maxlen);
      if (!(up || lo || dg)) begin
        r.gap = (cnt != 8'd0);
      end else if (sep && (({1'b0, cnt} + 9'd1) == {1'b0, maxlen})) begin
        // hyphen would take the final slot: drop it and its character
        r.cnt = maxlen;
        r.gap = 1'b0;
      end else begin
        r.gap = 1'b0;
        if (sep) begin
          r.c0  = CHAR_HYPHEN;
          r.n   = 2'd1;
          r.cnt = cnt + 8'd1;
        end
        if (r.cnt < maxlen) begin
          if (r.n == 2'd0) r.c0 = c;
          else             r.c1 = c;
          r.n   = r.n + 2'd1;
          r.cnt = r.cnt + 8'd1;
        end
      end
      return r;
    end
  endfunction

  logic [7:0]   cnt_r, cnt_nxt;
  logic         gap_r, gap_nxt;
  decode_mode_t mode_r, mode_nxt;

  logic         accept;
  logic         skip_cont;
  decode_mode_t mode_eff;
  logic         two_chars;
  logic [7:0]   ch_a;
  take_res_t    res1;
  take_res_t    res2;
  logic         take_any;
  logic [7:0]   cnt_post;
  logic         gap_post;
  logic [1:0]   n_tot;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 8'd0;
      gap_r  <= 1'b0;
      mode_r <= MODE_NORMAL;
    end else if (accept) begin
      cnt_r  <= cnt_nxt;
      gap_r  <= gap_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    skip_cont = (mode_r == MODE_SKIP) && (in_data.in_byte[7:6] == 2'b10);
    mode_eff  = (mode_r == MODE_SKIP) ? MODE_NORMAL : mode_r;
    mode_nxt  = mode_eff;
    take_any  = 1'b0;
    two_chars = 1'b0;
    ch_a      = CHAR_SPACE;

    if (skip_cont) begin
      mode_nxt = MODE_SKIP;
    end else begin
      unique case (mode_eff)
        MODE_AFTER_C3: begin
          mode_nxt = MODE_NORMAL;
          take_any = 1'b1;
          ch_a     = fold_after_c3(in_data.in_byte);
        end
        MODE_AFTER_C5: begin
          mode_nxt = MODE_NORMAL;
          take_any = 1'b1;
          if (in_data.in_byte == OE_UPPER || in_data.in_byte == OE_LOWER) begin
            ch_a      = "o";
            two_chars = 1'b1;
          end
        end
        default: begin
          if (!in_data.in_byte[7]) begin
            take_any = 1'b1;
            ch_a     = in_data.in_byte;
          end else if ((in_data.in_byte == LEAD_C3 || in_data.in_byte == LEAD_C5) &&
                       !in_data.end_of_name) begin
            mode_nxt = (in_data.in_byte == LEAD_C3) ? MODE_AFTER_C3 : MODE_AFTER_C5;
          end else begin
            take_any = 1'b1;
            mode_nxt = MODE_SKIP;
          end
        end
      endcase
    end

    res1 = take_char(cnt_r, gap_r, ch_a, max_len);
    res2 = take_char(res1.cnt, res1.gap, "e", max_len);

    if (!take_any) begin
      cnt_post = cnt_r;
      gap_post = gap_r;
      n_tot    = 2'd0;
    end else if (two_chars) begin
      cnt_post = res2.cnt;
      gap_post = res2.gap;
      n_tot    = res1.n + res2.n;
    end else begin
      cnt_post = res1.cnt;
      gap_post = res1.gap;
      n_tot    = res1.n;
    end

    q_data.n          = n_tot;
    q_data.ch[0]      = res1.c0;
    q_data.ch[1]      = (res1.n == 2'd2) ? res1.c1 : res2.c0;
    q_data.ch[2]      = res2.c0;
    q_data.last       = in_data.end_of_name;
    q_data.slug_empty = in_data.end_of_name && (cnt_post == 8'd0);

    q_push = accept && ((n_tot != 2'd0) || in_data.end_of_name);

    if (in_data.end_of_name) begin
      cnt_nxt  = 8'd0;
      gap_nxt  = 1'b0;
      mode_nxt = MODE_NORMAL;
    end else begin
      cnt_nxt = cnt_post;
      gap_nxt = gap_post;
    end
  end

  `U8S_ASSERT_NXT(a_end_clears, accept && in_data.end_of_name,
                  (mode_r == MODE_NORMAL) && (cnt_r == 8'd0) && !gap_r,
                  "name state not cleared after end of name")
  `U8S_ASSERT_IMP(a_bundle_kind, q_push, (q_data.n != 2'd0) || q_data.last,
                  "empty bundle pushed without end of name")
  `U8S_ASSERT_IMP(a_empty_nochar, q_push && q_data.slug_empty, q_data.n == 2'd0,
                  "empty slug flagged on a bundle with characters")

endmodule

`default_nettype wire

/* hdl/u8s_fifo.sv */
// Short register queue of result bundles between front and back ends.
// Depth from u8s_pkg::QUEUE_DEPTH.
`default_nettype none
`include "assert_macros.svh"

module u8s_fifo
  import u8s_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t push_data,
  input  wire logic    pop,
  output bundle_t      head,
  output logic         full,
  output logic         empty
);

  bundle_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     count_r;

  localparam logic [QPTR_W:0] DEPTH_CNT = (QPTR_W+1)'(QUEUE_DEPTH);
  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

  assign full  = (count_r == DEPTH_CNT);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `U8S_ASSERT_IMP(a_no_overflow, push, !full, "push into full queue")
  `U8S_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

/* hdl/u8s_back.sv */
// Back end: walks the head bundle one character per cycle into the output
// register while it is empty or being taken, then pops it. Uses u8s_pkg.
`default_nettype none
`include "assert_macros.svh"

module u8s_back
  import u8s_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire bundle_t head,
  input  wire logic    q_empty,
  output logic         q_pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_item_t    out_data
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  out_item_t  item_r, item_nxt;

  logic       load;
  logic       final_item;
  out_item_t  cur;

  assign out_valid = vld_r;
  assign out_data  = item_r;

  always_comb begin
    final_item = (head.n == 2'd0) || (idx_r == head.n - 2'd1);
    if (head.n == 2'd0) begin
      cur.out_byte   = 8'h00;
      cur.byte_valid = 1'b0;
    end else begin
      cur.out_byte   = head.ch[idx_r];
      cur.byte_valid = 1'b1;
    end
    cur.last       = head.last && final_item;
    cur.slug_empty = head.slug_empty && final_item;

    load     = !q_empty && (!vld_r || out_ready);
    q_pop    = load && final_item;
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (load) begin
      item_nxt = cur;
      vld_nxt  = 1'b1;
      idx_nxt  = final_item ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  `U8S_ASSERT_IMP(a_idx_range, !q_empty, (idx_r == 2'd0) || (idx_r < head.n),
                  "character index past bundle")
  `U8S_ASSERT_NXT(a_pop_rewinds, q_pop, idx_r == 2'd0,
                  "index not rewound after pop")

endmodule

`default_nettype wire

/* hdl/utf8_name_slug_stream.sv */
// Top level of the UTF-8 name slug stream: APB register, front end, bundle
// queue and back end. Uses u8s_pkg, u8s_front, u8s_fifo, u8s_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   in       | in_valid / in_ready       | in_data  (in_item_t)
//   out      | out_valid / out_ready     | out_data (out_item_t)
//   cfg      | psel, penable, pready     | paddr, pwdata, prdata
//
// A byte is decoded in the cycle it is accepted; its results are registered
// in the bundle queue and then loaded into the output register.
// Input takes a byte every cycle while the 4-deep bundle queue has room.
// Output delivers one item per cycle while a bundle is queued and the output
// register is free or taken; a byte giving three characters holds the back end until all three are out.
// Synchronous active-low reset; max_length resets to 128.
`default_nettype none

module utf8_name_slug_stream
  import u8s_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_MAX_LENGTH = 1'b0;

  logic [7:0] max_len_r;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  bundle_t    q_in;
  bundle_t    q_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_LENGTH) ? {24'd0, max_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LENGTH)) begin
      max_len_r <= pwdata[7:0];
    end
  end

  u8s_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .max_len  (max_len_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  u8s_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  u8s_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
